@@ src/ptm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptm_pkg
// shared types and constants for the page table mmu with frame allocator
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 12;
  localparam int unsigned VIRT_PAGES_DEF  = 16;
  localparam int unsigned PHYS_FRAMES_DEF = 16;

  localparam int unsigned VA_W     = 32;
  localparam int unsigned VP_W     = 32;
  localparam int unsigned PA_OUT_W = 16;
  localparam int unsigned FR_OUT_W = 4;
  localparam int unsigned ST_W     = 3;

  typedef enum logic {
    REQ_TRANSLATE = 1'b0,
    REQ_MAP       = 1'b1
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FAULT   = 3'd2,
    ST_BADPAGE = 3'd3,
    ST_NOFRAME = 3'd4
  } status_t;

endpackage

@@ src/page_table_mmu_with_frame_allocator_top.sv @@
// ----------------------------------------------------------------------------
// page_table_mmu_with_frame_allocator_top
// single-level page table translation with a bitmap frame allocator
// ----------------------------------------------------------------------------
// Takes one request per cycle and returns one result per request. The request
// is held in an input register; then the table lookup, the bounds checks and
// the lowest-free-frame search over the frame bitmap run in one pass into
// the result register. A translate returns frame * 2^OFFSET_BITS + offset
// and marks the page accessed; a map takes the lowest free frame and writes
// the page as present and writable, without freeing any frame it held before.
// Table and bitmap are cleared by reset, with no clearing pass. Back-pressure
// on the result side stalls the block.
// ----------------------------------------------------------------------------
module page_table_mmu_with_frame_allocator_top #(
  parameter int unsigned OFFSET_BITS = ptm_pkg::OFFSET_BITS_DEF,
  parameter int unsigned VIRT_PAGES  = ptm_pkg::VIRT_PAGES_DEF,
  parameter int unsigned PHYS_FRAMES = ptm_pkg::PHYS_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // virtual_address[31:0], map_page[63:32]
  input  logic        in_tuser,   // req_type[0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // physical_address[15:0], status[18:16],
                                  // frame_number[22:19], page_writable[23]
);

  localparam int unsigned PG_W = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
  localparam int unsigned FR_W = (PHYS_FRAMES > 1) ? $clog2(PHYS_FRAMES) : 1;
  localparam logic [ptm_pkg::VA_W:0] VA_LIMIT =
    (ptm_pkg::VA_W + 1)'(VIRT_PAGES) << OFFSET_BITS;
  localparam logic [ptm_pkg::VP_W-1:0] VP_LIMIT = ptm_pkg::VP_W'(VIRT_PAGES);
  localparam int unsigned PA_FULL_W = ptm_pkg::PA_OUT_W + FR_W + OFFSET_BITS;
  localparam int unsigned FR_FULL_W = ptm_pkg::FR_OUT_W + FR_W;

  // input register
  logic                      s1_vld_r;
  ptm_pkg::req_t             s1_req_r;
  logic [ptm_pkg::VA_W-1:0]  s1_va_r;
  logic [ptm_pkg::VP_W-1:0]  s1_vp_r;

  // page table and frame bitmap
  logic                      ent_present_r  [VIRT_PAGES];
  logic                      ent_writable_r [VIRT_PAGES];
  logic                      ent_accessed_r [VIRT_PAGES];
  logic [FR_W-1:0]           ent_frame_r    [VIRT_PAGES];
  logic [PHYS_FRAMES-1:0]    used_map_r;

  // result register
  logic                      out_vld_r;
  logic [ptm_pkg::PA_OUT_W-1:0] res_pa_r, res_pa_nxt;
  ptm_pkg::status_t             res_st_r, res_st_nxt;
  logic [ptm_pkg::FR_OUT_W-1:0] res_fr_r, res_fr_nxt;
  logic                         res_wr_r, res_wr_nxt;

  logic                      out_adv;
  logic                      s1_fire;
  logic [PG_W-1:0]           tr_page;
  logic [PG_W-1:0]           mp_page;
  logic [OFFSET_BITS-1:0]    tr_off;
  logic                      free_found;
  logic [FR_W-1:0]           free_idx;
  logic                      do_access;
  logic                      do_map;
  logic [PA_FULL_W-1:0]      pa_full;
  logic [FR_FULL_W-1:0]      fr_full;

  assign out_adv   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || out_adv;
  assign s1_fire   = s1_vld_r && out_adv;

  assign tr_page = s1_va_r[OFFSET_BITS +: PG_W];
  assign mp_page = s1_vp_r[PG_W-1:0];
  assign tr_off  = s1_va_r[OFFSET_BITS-1:0];

  // lowest free frame
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PHYS_FRAMES - 1; i >= 0; i--) begin
      if (!used_map_r[i]) begin
        free_found = 1'b1;
        free_idx   = FR_W'(i);
      end
    end
  end

  always_comb begin
    res_pa_nxt = '0;
    res_st_nxt = ptm_pkg::ST_OK;
    res_fr_nxt = '0;
    res_wr_nxt = 1'b0;
    do_access  = 1'b0;
    do_map     = 1'b0;
    pa_full    = '0;
    fr_full    = '0;
    case (s1_req_r)
      ptm_pkg::REQ_TRANSLATE: begin
        if ({1'b0, s1_va_r} >= VA_LIMIT) begin
          res_st_nxt = ptm_pkg::ST_RANGE;
        end else if (!ent_present_r[tr_page]) begin
          res_st_nxt = ptm_pkg::ST_FAULT;
        end else begin
          do_access  = 1'b1;
          pa_full    = {{ptm_pkg::PA_OUT_W{1'b0}}, ent_frame_r[tr_page], tr_off};
          fr_full    = {{ptm_pkg::FR_OUT_W{1'b0}}, ent_frame_r[tr_page]};
          res_pa_nxt = pa_full[ptm_pkg::PA_OUT_W-1:0];
          res_fr_nxt = fr_full[ptm_pkg::FR_OUT_W-1:0];
          res_wr_nxt = ent_writable_r[tr_page];
        end
      end
      ptm_pkg::REQ_MAP: begin
        if (s1_vp_r >= VP_LIMIT) begin
          res_st_nxt = ptm_pkg::ST_BADPAGE;
        end else if (!free_found) begin
          res_st_nxt = ptm_pkg::ST_NOFRAME;
        end else begin
          do_map     = 1'b1;
          fr_full    = {{ptm_pkg::FR_OUT_W{1'b0}}, free_idx};
          res_fr_nxt = fr_full[ptm_pkg::FR_OUT_W-1:0];
        end
      end
      default: begin
        res_st_nxt = ptm_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= ptm_pkg::req_t'(in_tuser);
      s1_va_r  <= in_tdata[31:0];
      s1_vp_r  <= in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_map_r <= '0;
      for (int p = 0; p < VIRT_PAGES; p++) begin
        ent_present_r[p]  <= 1'b0;
        ent_writable_r[p] <= 1'b0;
        ent_accessed_r[p] <= 1'b0;
        ent_frame_r[p]    <= '0;
      end
    end else if (s1_fire) begin
      if (do_access) begin
        ent_accessed_r[tr_page] <= 1'b1;
      end
      if (do_map) begin
        used_map_r[free_idx]    <= 1'b1;
        ent_present_r[mp_page]  <= 1'b1;
        ent_writable_r[mp_page] <= 1'b1;
        ent_frame_r[mp_page]    <= free_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_pa_r <= res_pa_nxt;
      res_st_r <= res_st_nxt;
      res_fr_r <= res_fr_nxt;
      res_wr_r <= res_wr_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_wr_r, res_fr_r, res_st_r, res_pa_r};

endmodule

@@ verif/ptm_translation_checker.sv @@
// ----------------------------------------------------------------------------
// ptm_translation_checker
// watches both streams of the page table mmu, keeps its own copy of the page
// table and frame bitmap, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module ptm_translation_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // virtual_address[31:0], map_page[63:32]
  input  logic        in_tuser,   // req_type[0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // physical_address[15:0], status[18:16],
                                  // frame_number[22:19], page_writable[23]
  output int          mismatches,
  output int          outstanding,
  output int          translations_ok,
  output int          maps_ok,
  output int          rejects,
  output int          frames_exhausted
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OFFSET_BITS = ptm_pkg::OFFSET_BITS_DEF;
  localparam int unsigned VIRT_PAGES  = ptm_pkg::VIRT_PAGES_DEF;
  localparam int unsigned PHYS_FRAMES = ptm_pkg::PHYS_FRAMES_DEF;

  typedef struct packed {
    logic                         phys_writable;
    logic [ptm_pkg::FR_OUT_W-1:0] frame;
    ptm_pkg::status_t             status;
    logic [ptm_pkg::PA_OUT_W-1:0] phys_addr;
  } mmu_result_t;

  logic                         page_present  [VIRT_PAGES];
  logic                         page_wr       [VIRT_PAGES];
  logic                         page_accessed [VIRT_PAGES];
  logic [ptm_pkg::FR_OUT_W-1:0] page_frame    [VIRT_PAGES];
  logic [PHYS_FRAMES-1:0]       frames_used;

  mmu_result_t pending_results [$];
  int err_count  = 0;
  int n_xlate_ok = 0;
  int n_map_ok   = 0;
  int n_reject   = 0;
  int n_noframe  = 0;

  function automatic mmu_result_t lookup_or_allocate(ptm_pkg::req_t kind,
                                                     logic [31:0] va,
                                                     logic [31:0] vp);
    mmu_result_t r;
    int unsigned pg;
    int free_frame;
    r = '0;
    r.status = ptm_pkg::ST_OK;
    if (kind == ptm_pkg::REQ_TRANSLATE) begin
      if ({32'd0, va} >= (64'(VIRT_PAGES) << OFFSET_BITS)) begin
        r.status = ptm_pkg::ST_RANGE;
      end else begin
        pg = va >> OFFSET_BITS;
        if (!page_present[pg]) begin
          r.status = ptm_pkg::ST_FAULT;
        end else begin
          page_accessed[pg] = 1'b1;
          r.phys_addr = ptm_pkg::PA_OUT_W'((32'(page_frame[pg]) << OFFSET_BITS)
                        + (va & ((32'd1 << OFFSET_BITS) - 1)));
          r.frame = page_frame[pg];
          r.phys_writable = page_wr[pg];
        end
      end
    end else begin
      if ({32'd0, vp} >= 64'(VIRT_PAGES)) begin
        r.status = ptm_pkg::ST_BADPAGE;
      end else begin
        free_frame = -1;
        for (int i = PHYS_FRAMES - 1; i >= 0; i--)
          if (!frames_used[i]) free_frame = i;
        if (free_frame < 0) begin
          r.status = ptm_pkg::ST_NOFRAME;
        end else begin
          // remap keeps the old frame allocated and the accessed bit as it was
          frames_used[free_frame] = 1'b1;
          page_frame[vp]   = ptm_pkg::FR_OUT_W'(free_frame);
          page_present[vp] = 1'b1;
          page_wr[vp]      = 1'b1;
          r.frame = ptm_pkg::FR_OUT_W'(free_frame);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    mmu_result_t want;
    mmu_result_t got;
    if (!rst_n) begin
      for (int p = 0; p < VIRT_PAGES; p++) begin
        page_present[p]  = 1'b0;
        page_wr[p]       = 1'b0;
        page_accessed[p] = 1'b0;
        page_frame[p]    = '0;
      end
      frames_used = '0;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = mmu_result_t'(out_tdata);
        if (pending_results.size() == 0) begin
          $error("result beat %h with no request outstanding", out_tdata);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.phys_addr !== want.phys_addr) begin
            $error("physical_address: expected %h, got %h", want.phys_addr, got.phys_addr);
            err_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
          end
          if (got.frame !== want.frame) begin
            $error("frame_number: expected %0d, got %0d", want.frame, got.frame);
            err_count++;
          end
          if (got.phys_writable !== want.phys_writable) begin
            $error("page_writable: expected %b, got %b", want.phys_writable,
                   got.phys_writable);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = lookup_or_allocate(ptm_pkg::req_t'(in_tuser), in_tdata[31:0],
                                  in_tdata[63:32]);
        case (want.status)
          ptm_pkg::ST_OK: begin
            if (ptm_pkg::req_t'(in_tuser) == ptm_pkg::REQ_MAP) n_map_ok++;
            else n_xlate_ok++;
          end
          ptm_pkg::ST_NOFRAME: n_noframe++;
          default: n_reject++;
        endcase
        pending_results.push_back(want);
      end
    end
    mismatches       <= err_count;
    outstanding      <= pending_results.size();
    translations_ok  <= n_xlate_ok;
    maps_ok          <= n_map_ok;
    rejects          <= n_reject;
    frames_exhausted <= n_noframe;
  end

endmodule

@@ verif/page_table_mmu_with_frame_allocator_top_test.sv @@
// ----------------------------------------------------------------------------
// page_table_mmu_with_frame_allocator_top_test
// drives translate and map requests into the mmu with random gaps and result
// back-pressure, including one long hold-off that fills the pipeline; a
// separate checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module page_table_mmu_with_frame_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 880;
  localparam int HOLD_CYCLES = 64;
  localparam int unsigned VA_SPAN = ptm_pkg::VIRT_PAGES_DEF << ptm_pkg::OFFSET_BITS_DEF;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  bit quiet_tail   = 1'b0;
  bit hold_request = 1'b0;
  int sender_gap_pct = 20;

  int mismatches;
  int outstanding;
  int translations_ok;
  int maps_ok;
  int rejects;
  int frames_exhausted;

  always #5 clk = ~clk;

  page_table_mmu_with_frame_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ptm_translation_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .translations_ok  (translations_ok),
    .maps_ok          (maps_ok),
    .rejects          (rejects),
    .frames_exhausted (frames_exhausted)
  );

  // offer one beat, wait for it to be taken, then maybe leave a gap
  task automatic issue(ptm_pkg::req_t kind, logic [31:0] va, logic [31:0] vp);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {vp, va};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(99) < sender_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue(ptm_pkg::REQ_TRANSLATE, 32'h0000_0000, 32'h0);
    issue(ptm_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(ptm_pkg::REQ_TRANSLATE, VA_SPAN, 32'h0);
    issue(ptm_pkg::REQ_TRANSLATE, VA_SPAN - 1, 32'h0);
    issue(ptm_pkg::REQ_MAP, 32'h0, 32'hFFFF_FFFF);
    issue(ptm_pkg::REQ_MAP, 32'h0, ptm_pkg::VIRT_PAGES_DEF);
    issue(ptm_pkg::REQ_MAP, 32'hFFFF_FFFF, 32'h0);
    issue(ptm_pkg::REQ_MAP, 32'h0, ptm_pkg::VIRT_PAGES_DEF - 1);
    issue(ptm_pkg::REQ_TRANSLATE, 32'h0000_0000, 32'h0);
    issue(ptm_pkg::REQ_TRANSLATE, VA_SPAN - 1, 32'h0);
    issue(ptm_pkg::REQ_MAP, 32'h0, 32'h0);
    issue(ptm_pkg::REQ_TRANSLATE, 32'h0000_0ABC, 32'h0);
    issue(ptm_pkg::REQ_TRANSLATE, 32'h0000_1000, 32'h0);
    issue(ptm_pkg::REQ_MAP, 32'h0, 32'h5);
    issue(ptm_pkg::REQ_TRANSLATE, 32'h0000_5FFF, 32'hFFFF_FFFF);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      ptm_pkg::req_t kind;
      logic [31:0] va;
      logic [31:0] vp;
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0: sender_gap_pct = 0;
          1: sender_gap_pct = 20;
          default: sender_gap_pct = 45;
        endcase
      end
      if (n == 300) hold_request = 1'b1;
      if (n == NUM_RANDOM - 100) quiet_tail = 1'b1;
      if ($urandom_range(99) < 8) kind = ptm_pkg::REQ_MAP;
      else kind = ptm_pkg::REQ_TRANSLATE;
      if ($urandom_range(99) < 85) va = 32'($urandom_range(0, VA_SPAN - 1));
      else va = $urandom;
      if ($urandom_range(99) < 85) begin
        vp = 32'($urandom_range(0, ptm_pkg::VIRT_PAGES_DEF - 1));
      end else begin
        vp = $urandom;
      end
      issue(kind, va, vp);
    end
    in_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    $display("covered %0d good translations, %0d frame allocations, %0d rejected requests",
             translations_ok, maps_ok, rejects);
    $display("and %0d maps refused once every frame was taken", frames_exhausted);
    if (mismatches == 0 && outstanding == 0) begin
      $display("page_table_mmu_with_frame_allocator_top_test: PASS");
    end else begin
      $display("page_table_mmu_with_frame_allocator_top_test: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(99) < 30) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_tready <= 1'b1;
      if ($urandom_range(3) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      else repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("page_table_mmu_with_frame_allocator_top_test: FAIL");
    $finish;
  end

endmodule
